// ----- hdl/lj_pair_energy_periodic_defines.svh -----
// Assertion macros shared by the pair energy block.
`ifndef LJ_PAIR_ENERGY_PERIODIC_DEFINES_SVH
`define LJ_PAIR_ENERGY_PERIODIC_DEFINES_SVH

// Same-cycle implication, clocked on clock and disabled in reset.
`define LJPE_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock and disabled in reset.
`define LJPE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/ljpe_pkg.sv -----
// Shared types and constants of the pair energy block.
`default_nettype none
package ljpe_pkg;

   localparam int MAX_GROUP_A_DEF = 1024;
   localparam int ATOM_W = 96;
   localparam int MUL_W = 33;
   localparam int PROD_W = 66;

   localparam logic signed [63:0] ENERGY_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] ENERGY_MIN = 64'sh8000_0000_0000_0000;

   localparam logic [2:0] CSR_EPS = 3'd0;
   localparam logic [2:0] CSR_SIGCUT = 3'd1;
   localparam logic [2:0] CSR_BOX0 = 3'd2;
   localparam logic [2:0] CSR_BOX1 = 3'd3;
   localparam logic [2:0] CSR_BOX2 = 3'd4;
   localparam logic [2:0] CSR_INV0 = 3'd5;
   localparam logic [2:0] CSR_INV1 = 3'd6;
   localparam logic [2:0] CSR_INV2 = 3'd7;

   typedef logic [2:0][20:0] row_type;
   typedef row_type [2:0] mat_type;

   typedef struct packed {
      logic [31:0] eps;
      logic [31:0] sigma;
      logic [31:0] cutoff;
      mat_type     box;
      mat_type     inv;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAIR,
      ST_DIV,
      ST_NEXT,
      ST_EMIT
   } state_type;

endpackage
`default_nettype wire

// ----- hdl/lj_pair_energy_periodic.sv -----
// Top level of the periodic Lennard-Jones pair energy block with its register file.
`default_nettype none
// A store word (req_type 0) is taken and busy stays low. A group B word keeps busy high
// while it is paired with each stored atom in turn: every pair runs through one shared
// 33x33 multiplier under a step sequencer. A pair ends early when it lies outside the
// cutoff or overlaps, or when sigma squared alone saturates the energy. It ends after the
// 28-step bit-serial division when the cubed ratio saturates, and otherwise once the full
// energy term is formed. With no stored atom a group B word without last leaves busy low.
// The word with last set then runs the final scaling, after which the result is shown for
// exactly one cycle on rsp_strobe. The receiver cannot stall the result. Registers are
// written through the csr port and must only change while busy is low.
`include "lj_pair_energy_periodic_defines.svh"
module lj_pair_energy_periodic #(
   parameter int MAX_GROUP_A = ljpe_pkg::MAX_GROUP_A_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_type,
   input  wire logic signed [31:0] req_pos_x,
   input  wire logic signed [31:0] req_pos_y,
   input  wire logic signed [31:0] req_pos_z,
   input  wire logic               req_last,
   output logic                    rsp_strobe,
   output logic      signed [63:0] rsp_energy,
   output logic                    rsp_overlap,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [63:0]        csr_data
);
   import ljpe_pkg::*;

   localparam int AW = (MAX_GROUP_A > 1) ? $clog2(MAX_GROUP_A) : 1;

   logic [31:0] eps_ff, sigma_ff, cutoff_ff;
   mat_type box_ff, inv_ff;
   cfg_type cfg;

   logic mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [ATOM_W-1:0] mem_wdata, mem_rdata;
   logic signed [MUL_W-1:0] mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_p;

   function automatic row_type unpack_row(input logic [62:0] v);
      row_type r;
      r[0] = v[20:0];
      r[1] = v[41:21];
      r[2] = v[62:42];
      return r;
   endfunction

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= '0;
         sigma_ff <= '0;
         cutoff_ff <= '0;
         box_ff <= '0;
         inv_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_EPS: eps_ff <= csr_data[31:0];
            CSR_SIGCUT: begin
               sigma_ff <= csr_data[31:0];
               cutoff_ff <= csr_data[63:32];
            end
            CSR_BOX0: box_ff[0] <= unpack_row(csr_data[62:0]);
            CSR_BOX1: box_ff[1] <= unpack_row(csr_data[62:0]);
            CSR_BOX2: box_ff[2] <= unpack_row(csr_data[62:0]);
            CSR_INV0: inv_ff[0] <= unpack_row(csr_data[62:0]);
            CSR_INV1: inv_ff[1] <= unpack_row(csr_data[62:0]);
            CSR_INV2: inv_ff[2] <= unpack_row(csr_data[62:0]);
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cfg.eps = eps_ff;
      cfg.sigma = sigma_ff;
      cfg.cutoff = cutoff_ff;
      cfg.box = box_ff;
      cfg.inv = inv_ff;
   end

   ljpe_store #(
      .DEPTH(MAX_GROUP_A),
      .AW(AW)
   ) u_store (
      .clock(clock),
      .we(mem_we),
      .waddr(mem_waddr),
      .wdata(mem_wdata),
      .raddr(mem_raddr),
      .rd_data(mem_rdata)
   );

   ljpe_mul u_mul (
      .clock(clock),
      .mul_a(mul_a),
      .mul_b(mul_b),
      .prod(mul_p)
   );

   ljpe_engine #(
      .MAX_GROUP_A(MAX_GROUP_A),
      .AW(AW)
   ) u_engine (
      .clock(clock),
      .reset(reset),
      .start(start),
      .req_type(req_type),
      .req_pos_x(req_pos_x),
      .req_pos_y(req_pos_y),
      .req_pos_z(req_pos_z),
      .req_last(req_last),
      .cfg(cfg),
      .busy(busy),
      .mem_we(mem_we),
      .mem_waddr(mem_waddr),
      .mem_wdata(mem_wdata),
      .mem_raddr(mem_raddr),
      .mem_rdata(mem_rdata),
      .mul_a(mul_a),
      .mul_b(mul_b),
      .mul_p(mul_p),
      .rsp_strobe(rsp_strobe),
      .rsp_energy(rsp_energy),
      .rsp_overlap(rsp_overlap)
   );

   `LJPE_ASSERT_NEXT(a_strobe_single, rsp_strobe, !rsp_strobe, "result word repeated")
   `LJPE_ASSERT_NOW(a_overlap_sat, rsp_strobe && rsp_overlap, rsp_energy == ENERGY_MAX, "overlap without saturated energy")
   `LJPE_ASSERT_NOW(a_strobe_ends_busy, rsp_strobe, $past(busy) && !busy, "result word outside the end of a busy period")

endmodule
`default_nettype wire

// ----- hdl/ljpe_store.sv -----
// Group A atom memory with one write port and a registered read port.
`default_nettype none
module ljpe_store #(
   parameter int DEPTH = ljpe_pkg::MAX_GROUP_A_DEF,
   parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                        clock,
   input  wire logic                        we,
   input  wire logic [AW-1:0]               waddr,
   input  wire logic [ljpe_pkg::ATOM_W-1:0] wdata,
   input  wire logic [AW-1:0]               raddr,
   output logic      [ljpe_pkg::ATOM_W-1:0] rd_data
);
   import ljpe_pkg::*;

   logic [ATOM_W-1:0] mem [DEPTH];
   logic [ATOM_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_data_ff <= mem[raddr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- hdl/ljpe_mul.sv -----
// Shared signed multiplier with a registered product.
`default_nettype none
module ljpe_mul (
   input  wire logic                               clock,
   input  wire logic signed [ljpe_pkg::MUL_W-1:0]  mul_a,
   input  wire logic signed [ljpe_pkg::MUL_W-1:0]  mul_b,
   output logic      signed [ljpe_pkg::PROD_W-1:0] prod
);
   import ljpe_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   assign prod = prod_ff;

endmodule
`default_nettype wire

// ----- hdl/ljpe_engine.sv -----
// Sequencer and datapath that walk each group B atom over the stored group A atoms.
`default_nettype none
module ljpe_engine #(
   parameter int MAX_GROUP_A = ljpe_pkg::MAX_GROUP_A_DEF,
   parameter int AW = (MAX_GROUP_A > 1) ? $clog2(MAX_GROUP_A) : 1
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic                               req_type,
   input  wire logic signed [31:0]                 req_pos_x,
   input  wire logic signed [31:0]                 req_pos_y,
   input  wire logic signed [31:0]                 req_pos_z,
   input  wire logic                               req_last,
   input  wire ljpe_pkg::cfg_type                  cfg,
   output logic                                    busy,
   output logic                                    mem_we,
   output logic      [AW-1:0]                      mem_waddr,
   output logic      [ljpe_pkg::ATOM_W-1:0]        mem_wdata,
   output logic      [AW-1:0]                      mem_raddr,
   input  wire logic [ljpe_pkg::ATOM_W-1:0]        mem_rdata,
   output logic      signed [ljpe_pkg::MUL_W-1:0]  mul_a,
   output logic      signed [ljpe_pkg::MUL_W-1:0]  mul_b,
   input  wire logic signed [ljpe_pkg::PROD_W-1:0] mul_p,
   output logic                                    rsp_strobe,
   output logic      signed [63:0]                 rsp_energy,
   output logic                                    rsp_overlap
);
   import ljpe_pkg::*;

   localparam int CW = $clog2(MAX_GROUP_A + 1);
   localparam logic signed [48:0] HALF_Q32 = 49'sd2147483648;
   localparam logic signed [48:0] NHALF_Q32 = -49'sd2147483648;
   localparam logic [31:0] MIN_PARAM_RAW = 32'd66;
   localparam logic [63:0] OVERLAP_RSQ_RAW = 64'd10996;
   localparam logic [33:0] TERM_LIMIT_C = 34'd46342 << 16;
   localparam logic [63:0] PHI_LIMIT = 64'd1 << 45;
   localparam logic [4:0] DIV_LAST = 5'd27;

   state_type state_ff, state_in;
   logic [4:0] step_ff, step_in;
   logic [4:0] dcnt_ff;
   logic [CW-1:0] count_ff;
   logic [AW-1:0] idx_ff;
   logic signed [63:0] sum_ff;
   logic ovl_ff;
   logic strobe_ff;

   logic signed [31:0] bx_ff, by_ff, bz_ff;
   logic last_ff;
   logic signed [55:0] acc_ff;
   logic signed [32:0] s0_ff, s1_ff, s2_ff;
   logic signed [31:0] r0_ff, r1_ff, r2_ff;
   logic [63:0] rsq_ff, rem_ff, mag_ff, plo_ff;
   logic [27:0] q_ff;
   logic [33:0] c_ff;
   logic signed [63:0] energy_ff;
   logic overlap_ff;

   logic accept, at_last;
   logic signed [32:0] d0, d1, d2;
   logic signed [55:0] acc_sum;
   logic cut_out, ovl_hit, big_q, c_big, term_big;
   logic signed [64:0] sadd;
   logic signed [63:0] sum_sat;
   logic [63:0] rem_sh;
   logic rem_ge;
   logic [63:0] phi, res;
   logic signed [63:0] scaled;
   logic disabled;

   function automatic logic signed [32:0] ext_ent(input logic [20:0] e);
      return {{12{e[20]}}, e};
   endfunction

   function automatic logic signed [32:0] wrap_frac(input logic signed [55:0] a);
      logic signed [55:0] rnd;
      logic signed [48:0] sr;
      logic signed [32:0] v;
      rnd = a + 56'sd64;
      sr = rnd[55:7];
      v = {sr[31], sr[31:0]};
      if (sr > HALF_Q32) begin
         return (sr[31:0] == 32'h8000_0000) ? 33'sh0_8000_0000 : v;
      end else if (sr < NHALF_Q32) begin
         return v;
      end
      return sr[32:0];
   endfunction

   function automatic logic signed [31:0] round_r(input logic signed [55:0] a);
      logic signed [55:0] t;
      t = a + 56'sd8388608;
      return t[55:24];
   endfunction

   assign accept = start && (state_ff == ST_IDLE);
   assign at_last = (CW'(idx_ff) + CW'(1)) == count_ff;

   assign d0 = {mem_rdata[31], mem_rdata[31:0]} - {bx_ff[31], bx_ff};
   assign d1 = {mem_rdata[63], mem_rdata[63:32]} - {by_ff[31], by_ff};
   assign d2 = {mem_rdata[95], mem_rdata[95:64]} - {bz_ff[31], bz_ff};
   assign acc_sum = acc_ff + $signed(mul_p[55:0]);

   assign cut_out = {8'b0, rsq_ff[63:8]} >= mul_p[63:0];
   assign ovl_hit = rsq_ff < OVERLAP_RSQ_RAW;
   assign big_q = mul_p[63:0] >= ((rsq_ff + 64'd3) >> 2);
   assign c_big = c_ff >= TERM_LIMIT_C;
   assign term_big = !mul_p[65] && (mul_p[64] || mul_p[63]);
   assign sadd = {sum_ff[63], sum_ff} + $signed(mul_p[64:0]);
   assign sum_sat = (sadd[64] != sadd[63]) ? (sadd[64] ? ENERGY_MIN : ENERGY_MAX)
                                           : sadd[63:0];
   assign rem_sh = {rem_ff[62:0], 1'b0};
   assign rem_ge = rem_sh >= rsq_ff;

   assign phi = mul_p[63:0];
   assign res = {phi[44:0], 18'b0} + {14'b0, plo_ff[63:14]};
   assign disabled = (cfg.eps < MIN_PARAM_RAW) || (cfg.sigma < MIN_PARAM_RAW) ||
                     (cfg.cutoff < MIN_PARAM_RAW) || (count_ff == '0);

   always_comb begin
      if (phi >= PHI_LIMIT) begin
         scaled = sum_ff[63] ? ENERGY_MIN : ENERGY_MAX;
      end else if (sum_ff[63]) begin
         scaled = res[63] ? ENERGY_MIN : -$signed(res);
      end else begin
         scaled = res[63] ? ENERGY_MAX : $signed(res);
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_type) begin
               step_in = '0;
               if (count_ff == '0) begin
                  state_in = req_last ? ST_EMIT : ST_IDLE;
               end else begin
                  state_in = ST_PAIR;
               end
            end
         end
         ST_PAIR: begin
            step_in = step_ff + 5'd1;
            priority if (step_ff == 5'd25 && (cut_out || ovl_hit)) begin
               state_in = ST_NEXT;
            end else if (step_ff == 5'd26) begin
               state_in = big_q ? ST_NEXT : ST_DIV;
            end else if (step_ff == 5'd30 && c_big) begin
               state_in = ST_NEXT;
            end else if (step_ff == 5'd31) begin
               state_in = ST_NEXT;
            end
         end
         ST_DIV: begin
            if (dcnt_ff == DIV_LAST) begin
               state_in = ST_PAIR;
            end
         end
         ST_NEXT: begin
            step_in = '0;
            if (at_last) begin
               state_in = last_ff ? ST_EMIT : ST_IDLE;
            end else begin
               state_in = ST_PAIR;
            end
         end
         ST_EMIT: begin
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd3) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy = state_ff != ST_IDLE;
      mem_we = accept && !req_type && (count_ff < CW'(MAX_GROUP_A));
      mem_waddr = count_ff[AW-1:0];
      mem_wdata = {req_pos_z, req_pos_y, req_pos_x};
      mem_raddr = idx_ff;
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_PAIR) begin
         unique case (step_ff)
            5'd1:  begin mul_a = ext_ent(cfg.inv[0][0]); mul_b = d0; end
            5'd2:  begin mul_a = ext_ent(cfg.inv[0][1]); mul_b = d1; end
            5'd3:  begin mul_a = ext_ent(cfg.inv[0][2]); mul_b = d2; end
            5'd4:  begin mul_a = ext_ent(cfg.inv[1][0]); mul_b = d0; end
            5'd5:  begin mul_a = ext_ent(cfg.inv[1][1]); mul_b = d1; end
            5'd6:  begin mul_a = ext_ent(cfg.inv[1][2]); mul_b = d2; end
            5'd7:  begin mul_a = ext_ent(cfg.inv[2][0]); mul_b = d0; end
            5'd8:  begin mul_a = ext_ent(cfg.inv[2][1]); mul_b = d1; end
            5'd9:  begin mul_a = ext_ent(cfg.inv[2][2]); mul_b = d2; end
            5'd12: begin mul_a = ext_ent(cfg.box[0][0]); mul_b = s0_ff; end
            5'd13: begin mul_a = ext_ent(cfg.box[0][1]); mul_b = s1_ff; end
            5'd14: begin mul_a = ext_ent(cfg.box[0][2]); mul_b = s2_ff; end
            5'd15: begin mul_a = ext_ent(cfg.box[1][0]); mul_b = s0_ff; end
            5'd16: begin mul_a = ext_ent(cfg.box[1][1]); mul_b = s1_ff; end
            5'd17: begin mul_a = ext_ent(cfg.box[1][2]); mul_b = s2_ff; end
            5'd18: begin mul_a = ext_ent(cfg.box[2][0]); mul_b = s0_ff; end
            5'd19: begin mul_a = ext_ent(cfg.box[2][1]); mul_b = s1_ff; end
            5'd20: begin mul_a = ext_ent(cfg.box[2][2]); mul_b = s2_ff; end
            5'd21: begin mul_a = {r0_ff[31], r0_ff}; mul_b = {r0_ff[31], r0_ff}; end
            5'd22: begin mul_a = {r1_ff[31], r1_ff}; mul_b = {r1_ff[31], r1_ff}; end
            5'd23: begin mul_a = {r2_ff[31], r2_ff}; mul_b = {r2_ff[31], r2_ff}; end
            5'd24: begin mul_a = {1'b0, cfg.cutoff}; mul_b = {1'b0, cfg.cutoff}; end
            5'd25: begin mul_a = {1'b0, cfg.sigma}; mul_b = {1'b0, cfg.sigma}; end
            5'd27: begin mul_a = {5'b0, q_ff}; mul_b = {5'b0, q_ff}; end
            5'd28: begin mul_a = {1'b0, mul_p[51:20]}; mul_b = {5'b0, q_ff}; end
            5'd30: begin
               mul_a = {1'b0, c_ff[31:0]};
               mul_b = {1'b0, c_ff[31:0]} - 33'sd65536;
            end
            default: begin
               mul_a = '0;
               mul_b = '0;
            end
         endcase
      end else if (state_ff == ST_EMIT) begin
         if (step_ff == 5'd1) begin
            mul_a = {1'b0, mag_ff[31:0]};
            mul_b = {1'b0, cfg.eps};
         end else if (step_ff == 5'd2) begin
            mul_a = {1'b0, mag_ff[63:32]};
            mul_b = {1'b0, cfg.eps};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= '0;
         dcnt_ff <= '0;
         count_ff <= '0;
         idx_ff <= '0;
         sum_ff <= '0;
         ovl_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         strobe_ff <= 1'b0;
         if (mem_we) begin
            count_ff <= count_ff + CW'(1);
         end
         if (accept && req_type) begin
            idx_ff <= '0;
         end
         if (state_ff == ST_NEXT && !at_last) begin
            idx_ff <= idx_ff + AW'(1);
         end
         if (state_ff == ST_DIV) begin
            dcnt_ff <= dcnt_ff + 5'd1;
         end
         if (state_ff == ST_PAIR) begin
            if (step_ff == 5'd25 && !cut_out && ovl_hit) begin
               ovl_ff <= 1'b1;
            end
            if (step_ff == 5'd26) begin
               dcnt_ff <= '0;
               if (big_q) begin
                  sum_ff <= ENERGY_MAX;
               end
            end
            if (step_ff == 5'd30 && c_big) begin
               sum_ff <= ENERGY_MAX;
            end
            if (step_ff == 5'd31) begin
               sum_ff <= term_big ? ENERGY_MAX : sum_sat;
            end
         end
         if (state_ff == ST_EMIT && step_ff == 5'd3) begin
            strobe_ff <= 1'b1;
            count_ff <= '0;
            sum_ff <= '0;
            ovl_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_type) begin
         bx_ff <= req_pos_x;
         by_ff <= req_pos_y;
         bz_ff <= req_pos_z;
         last_ff <= req_last;
      end
      if (state_ff == ST_PAIR) begin
         unique case (step_ff)
            5'd2, 5'd13: acc_ff <= $signed(mul_p[55:0]);
            5'd3, 5'd4, 5'd6, 5'd7, 5'd9, 5'd10, 5'd14, 5'd15, 5'd17, 5'd18, 5'd20,
            5'd21: acc_ff <= acc_sum;
            5'd5: begin
               s0_ff <= wrap_frac(acc_ff);
               acc_ff <= $signed(mul_p[55:0]);
            end
            5'd8: begin
               s1_ff <= wrap_frac(acc_ff);
               acc_ff <= $signed(mul_p[55:0]);
            end
            5'd11: s2_ff <= wrap_frac(acc_ff);
            5'd16: begin
               r0_ff <= round_r(acc_ff);
               acc_ff <= $signed(mul_p[55:0]);
            end
            5'd19: begin
               r1_ff <= round_r(acc_ff);
               acc_ff <= $signed(mul_p[55:0]);
            end
            5'd22: begin
               r2_ff <= round_r(acc_ff);
               rsq_ff <= mul_p[63:0];
            end
            5'd23, 5'd24: rsq_ff <= rsq_ff + mul_p[63:0];
            5'd26: begin
               rem_ff <= mul_p[63:0];
               q_ff <= '0;
            end
            5'd29: c_ff <= mul_p[57:24];
            default: begin
            end
         endcase
      end
      if (state_ff == ST_DIV) begin
         rem_ff <= rem_ge ? (rem_sh - rsq_ff) : rem_sh;
         q_ff <= {q_ff[26:0], rem_ge};
      end
      if (state_ff == ST_EMIT) begin
         if (step_ff == 5'd0) begin
            mag_ff <= sum_ff[63] ? (64'd0 - sum_ff) : sum_ff;
         end
         if (step_ff == 5'd2) begin
            plo_ff <= mul_p[63:0];
         end
         if (step_ff == 5'd3) begin
            energy_ff <= disabled ? 64'sd0 : (ovl_ff ? ENERGY_MAX : scaled);
            overlap_ff <= !disabled && ovl_ff;
         end
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_energy = energy_ff;
   assign rsp_overlap = overlap_ff;

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the periodic Lennard-Jones pair energy block.
`default_nettype none
module tb_top;
   import ljpe_pkg::*;

   localparam logic KIND_STORE = 1'b0;
   localparam logic KIND_EVAL = 1'b1;
   localparam int GROUP_DEPTH = 1024;
   localparam longint unsigned MIN_PARAM = 64'd66;
   localparam longint unsigned OVERLAP_RSQ = 64'd10996;
   localparam longint HALF_Q32 = 64'sd1 <<< 31;
   localparam longint ONE_Q32 = 64'sd1 <<< 32;

   typedef struct {
      logic              kind;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic              last;
   } atom_word_type;

   typedef struct {
      logic signed [63:0] energy;
      logic              overlap;
   } energy_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_type = 1'b0;
   logic signed [31:0] req_pos_x = '0;
   logic signed [31:0] req_pos_y = '0;
   logic signed [31:0] req_pos_z = '0;
   logic req_last = 1'b0;
   logic rsp_strobe;
   logic signed [63:0] rsp_energy;
   logic rsp_overlap;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [63:0] csr_data = '0;

   atom_word_type pending_words[$];
   energy_word_type energy_due[$];
   int errors = 0;
   int words_queued = 0;
   int totals_seen = 0;
   int overlaps_seen = 0;

   // Predictor copy of configuration and group state.
   longint unsigned eps_v, sigma_v, cutoff_v;
   longint box_m[3][3];
   longint inv_m[3][3];
   longint group_pos[GROUP_DEPTH][3];
   int group_count = 0;
   longint pair_sum = 0;
   logic overlap_flag = 1'b0;

   lj_pair_energy_periodic dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_pos_x(req_pos_x), .req_pos_y(req_pos_y),
      .req_pos_z(req_pos_z), .req_last(req_last),
      .rsp_strobe(rsp_strobe), .rsp_energy(rsp_energy), .rsp_overlap(rsp_overlap),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void add_saturated(longint t);
      if (t > 0 && pair_sum > ENERGY_MAX - t) pair_sum = ENERGY_MAX;
      else if (t < 0 && pair_sum < ENERGY_MIN - t) pair_sum = ENERGY_MIN;
      else pair_sum = pair_sum + t;
   endfunction

   function automatic void accumulate_pair(int idx, longint bx, longint by, longint bz);
      longint d[3], s[3];
      longint acc, n, r;
      longint unsigned rsq, num, den, rem, q, q2, q3, c, t;
      d[0] = group_pos[idx][0] - bx;
      d[1] = group_pos[idx][1] - by;
      d[2] = group_pos[idx][2] - bz;
      for (int k = 0; k < 3; k++) begin
         acc = 0;
         for (int m = 0; m < 3; m++) acc = acc + inv_m[k][m] * d[m];
         s[k] = (acc + 64'sd64) >>> 7;
         if (s[k] > HALF_Q32) begin
            n = (s[k] - HALF_Q32 + ONE_Q32 - 1) >>> 32;
            s[k] = s[k] - (n <<< 32);
         end else if (s[k] < -HALF_Q32) begin
            n = (s[k] + HALF_Q32) >>> 32;
            s[k] = s[k] - (n <<< 32);
         end
      end
      rsq = 0;
      for (int k = 0; k < 3; k++) begin
         acc = 0;
         for (int m = 0; m < 3; m++) acc = acc + box_m[k][m] * s[m];
         r = (acc + (64'sd1 <<< 23)) >>> 24;
         rsq = rsq + $unsigned(r * r);
      end
      if ((rsq >> 8) >= cutoff_v * cutoff_v) return;
      if (rsq < OVERLAP_RSQ) begin
         overlap_flag = 1'b1;
         return;
      end
      num = sigma_v * sigma_v;
      den = rsq;
      if (num >= ((den + 64'd3) >> 2)) begin
         pair_sum = ENERGY_MAX;
         return;
      end
      rem = num;
      q = 0;
      for (int k = 0; k < 28; k++) begin
         rem = rem << 1;
         q = q << 1;
         if (rem >= den) begin
            rem = rem - den;
            q = q | 64'd1;
         end
      end
      q2 = (q * q) >> 20;
      q3 = (q2 * q) >> 20;
      c = q3 >> 4;
      if (c >= (64'd46342 << 16)) begin
         pair_sum = ENERGY_MAX;
         return;
      end
      if (c >= 64'd65536) begin
         t = c * (c - 64'd65536);
         if (t[63]) pair_sum = ENERGY_MAX;
         else add_saturated($signed(t));
      end else begin
         add_saturated(-$signed(c * (64'd65536 - c)));
      end
   endfunction

   function automatic logic signed [63:0] scaled_total();
      longint unsigned mag, al, ah, plo, phi, res;
      logic neg;
      neg = pair_sum < 0;
      mag = $unsigned(pair_sum);
      if (neg) mag = 64'd0 - mag;
      al = mag & 64'hFFFF_FFFF;
      ah = mag >> 32;
      plo = al * eps_v;
      phi = ah * eps_v;
      if (phi >= (64'd1 << 45)) return neg ? ENERGY_MIN : ENERGY_MAX;
      res = (phi << 18) + (plo >> 14);
      if (neg) return res[63] ? ENERGY_MIN : -$signed(res);
      return res[63] ? ENERGY_MAX : $signed(res);
   endfunction

   function automatic void predict_word(atom_word_type w);
      energy_word_type e;
      if (w.kind == KIND_STORE) begin
         if (group_count < GROUP_DEPTH) begin
            group_pos[group_count][0] = w.x;
            group_pos[group_count][1] = w.y;
            group_pos[group_count][2] = w.z;
            group_count++;
         end
         return;
      end
      for (int i = 0; i < group_count; i++) accumulate_pair(i, w.x, w.y, w.z);
      if (!w.last) return;
      if (eps_v < MIN_PARAM || sigma_v < MIN_PARAM || cutoff_v < MIN_PARAM ||
          group_count == 0) begin
         e.energy = '0;
         e.overlap = 1'b0;
      end else if (overlap_flag) begin
         e.energy = ENERGY_MAX;
         e.overlap = 1'b1;
      end else begin
         e.energy = scaled_total();
         e.overlap = 1'b0;
      end
      energy_due.push_back(e);
      group_count = 0;
      pair_sum = 0;
      overlap_flag = 1'b0;
   endfunction

   function automatic void apply_register(logic [2:0] idx, logic [63:0] val);
      longint row[3];
      for (int m = 0; m < 3; m++) row[m] = $signed(val[21*m +: 21]);
      case (idx)
         CSR_EPS: eps_v = val[31:0];
         CSR_SIGCUT: begin
            sigma_v = val[31:0];
            cutoff_v = val[63:32];
         end
         CSR_BOX0, CSR_BOX1, CSR_BOX2: box_m[idx - CSR_BOX0] = row;
         default: inv_m[idx - CSR_INV0] = row;
      endcase
   endfunction

   // Sender: bursts of random length separated by random gaps.
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else if (pending_words.size() > 0) begin
            atom_word_type w;
            w = pending_words.pop_front();
            start <= 1'b1;
            req_type <= w.kind;
            req_pos_x <= w.x;
            req_pos_y <= w.y;
            req_pos_z <= w.z;
            req_last <= w.last;
            if (burst_left <= 0) begin
               burst_left <= $urandom_range(1, 24);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         atom_word_type w;
         w.kind = req_type;
         w.x = req_pos_x;
         w.y = req_pos_y;
         w.z = req_pos_z;
         w.last = req_last;
         predict_word(w);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         energy_word_type e;
         totals_seen++;
         if (rsp_overlap) overlaps_seen++;
         if (energy_due.size() == 0) begin
            $error("result word with no expectation: energy %h overlap %b",
                   rsp_energy, rsp_overlap);
            errors++;
         end else begin
            e = energy_due.pop_front();
            if (rsp_energy !== e.energy) begin
               $error("energy mismatch: expected %h actual %h", e.energy, rsp_energy);
               errors++;
            end
            if (rsp_overlap !== e.overlap) begin
               $error("overlap mismatch: expected %b actual %b", e.overlap, rsp_overlap);
               errors++;
            end
         end
      end
   end

   task automatic push_word(logic kind, logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z, logic last);
      atom_word_type w;
      w.kind = kind;
      w.x = x;
      w.y = y;
      w.z = z;
      w.last = last;
      pending_words.push_back(w);
      words_queued++;
   endtask

   task automatic wait_idle();
      do begin
         @(posedge clock);
         #1;
      end while (pending_words.size() != 0 || start || busy || energy_due.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_register(logic [2:0] idx, logic [63:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      apply_register(idx, val);
   endtask

   function automatic logic [62:0] pack_row(int c0, int c1, int c2);
      return {21'(c2), 21'(c1), 21'(c0)};
   endfunction

   task automatic load_all(logic [31:0] eps, logic [31:0] sigma, logic [31:0] cutoff,
                           logic [62:0] b0, logic [62:0] b1, logic [62:0] b2,
                           logic [62:0] i0, logic [62:0] i1, logic [62:0] i2);
      wait_idle();
      write_register(CSR_EPS, {32'd0, eps});
      write_register(CSR_SIGCUT, {cutoff, sigma});
      write_register(CSR_BOX0, {1'b0, b0});
      write_register(CSR_BOX1, {1'b0, b1});
      write_register(CSR_BOX2, {1'b0, b2});
      write_register(CSR_INV0, {1'b0, i0});
      write_register(CSR_INV1, {1'b0, i1});
      write_register(CSR_INV2, {1'b0, i2});
   endtask

   // Orthorhombic or slightly tilted box of edge len, with a matching inverse.
   task automatic load_box(logic [31:0] eps, logic [31:0] sigma, logic [31:0] cutoff,
                           int len, int tilt);
      int inv_diag, inv_tilt;
      inv_diag = ((1 << 19) + len / 2) / len;
      inv_tilt = -((tilt << 19) / (len * len));
      load_all(eps, sigma, cutoff,
               pack_row(len << 12, tilt << 12, 0), pack_row(0, len << 12, 0),
               pack_row(0, 0, len << 12),
               pack_row(inv_diag, inv_tilt, 0), pack_row(0, inv_diag, 0),
               pack_row(0, 0, inv_diag));
   endtask

   function automatic logic signed [31:0] coord_in(int len);
      int span;
      span = len << 20;
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 4 * span) - 2 * span;
      return $urandom_range(0, span);
   endfunction

   task automatic add_group(int len);
      logic signed [31:0] ax[$], ay[$], az[$];
      int na, nb, pick;
      logic signed [31:0] x, y, z;
      na = ($urandom_range(0, 14) == 0) ? 0 : $urandom_range(1, 6);
      for (int i = 0; i < na; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            x = $urandom;
            y = $urandom;
            z = $urandom;
         end else begin
            x = coord_in(len);
            y = coord_in(len);
            z = coord_in(len);
         end
         ax.push_back(x);
         ay.push_back(y);
         az.push_back(z);
         push_word(KIND_STORE, x, y, z, $urandom_range(0, 3) == 0);
      end
      nb = $urandom_range(1, 3);
      for (int j = 0; j < nb; j++) begin
         if ($urandom_range(0, 4) == 0) begin
            push_word(KIND_STORE, coord_in(len), coord_in(len), coord_in(len), 1'b0);
         end
         pick = $urandom_range(0, 19);
         if (ax.size() > 0 && pick == 0) begin
            pick = $urandom_range(0, ax.size() - 1);
            x = ax[pick];
            y = ay[pick];
            z = az[pick];
         end else if (ax.size() > 0 && pick < 4) begin
            pick = $urandom_range(0, ax.size() - 1);
            x = ax[pick] + $urandom_range(0, 1 << 21) - (1 << 20);
            y = ay[pick] + $urandom_range(0, 1 << 21) - (1 << 20);
            z = az[pick] + $urandom_range(0, 1 << 21) - (1 << 20);
         end else if (pick == 4) begin
            x = $urandom;
            y = $urandom;
            z = $urandom;
         end else begin
            x = coord_in(len);
            y = coord_in(len);
            z = coord_in(len);
         end
         push_word(KIND_EVAL, x, y, z, j == nb - 1);
      end
   endtask

   task automatic random_phase(int len, int count);
      int goal;
      goal = words_queued + count;
      while (words_queued < goal) add_group(len);
   endtask

   initial begin
      int len;
      logic [62:0] r[6];
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Registers still at reset: the block is disabled and reports zero.
      push_word(KIND_STORE, 32'sd0, 32'sd0, 32'sd0, 1'b0);
      push_word(KIND_EVAL, 32'sd1 <<< 20, 32'sd0, 32'sd0, 1'b1);

      load_box(32'd13107, 32'd222822, 32'd10 << 16, 20, 0);
      push_word(KIND_EVAL, 32'sd5, 32'sd5, 32'sd5, 1'b1);
      push_word(KIND_STORE, 32'h7FFF_FFFF, 32'h8000_0000, 32'sd0, 1'b1);
      push_word(KIND_STORE, 32'sd3 <<< 20, 32'sd3 <<< 20, 32'sd3 <<< 20, 1'b0);
      push_word(KIND_EVAL, 32'sd7 <<< 20, 32'sd3 <<< 20, 32'sd3 <<< 20, 1'b0);
      push_word(KIND_STORE, 32'sd10 <<< 20, 32'sd10 <<< 20, 32'sd10 <<< 20, 1'b0);
      push_word(KIND_EVAL, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      push_word(KIND_STORE, 32'sd1 <<< 20, 32'sd1 <<< 20, 32'sd1 <<< 20, 1'b0);
      push_word(KIND_EVAL, 32'sd1 <<< 20, 32'sd1 <<< 20, 32'sd1 <<< 20, 1'b1);
      push_word(KIND_STORE, 32'sd2 <<< 20, 32'sd2 <<< 20, 32'sd2 <<< 20, 1'b0);
      push_word(KIND_EVAL, (32'sd2 <<< 20) + 32'sd300000, 32'sd2 <<< 20, 32'sd2 <<< 20,
                1'b1);
      push_word(KIND_STORE, -(32'sd19 <<< 20), 32'sd0, 32'sd0, 1'b0);
      push_word(KIND_EVAL, 32'sd19 <<< 20, 32'sd0, 32'sd0, 1'b1);

      load_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               {63{1'b1}}, pack_row(20'hFFFFF, 20'hFFFFF, 20'hFFFFF),
               pack_row(-(1 << 20), -(1 << 20), -(1 << 20)),
               {63{1'b1}}, pack_row(20'hFFFFF, 0, 0), 63'd0);
      push_word(KIND_STORE, 32'sd123456, -32'sd654321, 32'sd1, 1'b0);
      push_word(KIND_EVAL, -32'sd1, 32'sd77, 32'h7FFF_FFFF, 1'b1);

      for (int p = 0; p < 12; p++) begin
         len = $urandom_range(8, 60);
         case (p % 4)
            0: load_box($urandom_range(66, 200000), $urandom_range(100000, 300000),
                        $urandom_range(3, 12) << 16, len, $urandom_range(0, 3));
            1: load_box($urandom_range(0, 1) ? 32'd65 : 32'd66, 32'd66 - $urandom_range(0, 1),
                        32'd66, len, 0);
            2: begin
               for (int k = 0; k < 6; k++) r[k] = 63'({$urandom, $urandom});
               load_all($urandom, $urandom, $urandom, r[0], r[1], r[2], r[3], r[4], r[5]);
            end
            default: load_box($urandom_range(1000, 65536), $urandom_range(150000, 250000),
                              32'hFFFF_FFFF - $urandom_range(0, 1), len, 0);
         endcase
         random_phase(len, 44);
      end

      wait_idle();
      repeat (80) @(posedge clock);
      $display("Queued %0d words across 14 register settings with bursty input.",
               words_queued);
      $display("Checked %0d energy totals, %0d of them with overlap.", totals_seen,
               overlaps_seen);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #(12 * 3000000);
      $display("status: fail");
      $finish;
   end

endmodule
`default_nettype wire

// ----- lj_pair_energy_periodic.f -----
+incdir+hdl
hdl/ljpe_pkg.sv
hdl/ljpe_store.sv
hdl/ljpe_mul.sv
hdl/ljpe_engine.sv
hdl/lj_pair_energy_periodic.sv
tb/sv/tb_top.sv
